// ===== sv/deqs_pkg.sv =====
// ----------------------------------------------------------------------------
// deqs_pkg
// shared types, codes and defaults for the double-ended queue with search
// ----------------------------------------------------------------------------
package deqs_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int WORD_W    = 32;
  localparam int KIND_W    = 3;
  localparam int STATUS_W  = 2;
  localparam int POS_W     = 4;
  localparam int OCC_W     = 5;

  localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
  localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_DROP_FRONT = 3'd2;
  localparam logic [KIND_W-1:0] KIND_DROP_BACK  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_SEARCH     = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef logic [KIND_W-1:0]          kind_t;
  typedef logic signed [WORD_W-1:0]   word_t;
  typedef logic [STATUS_W-1:0]        status_t;

  // controller to datapath
  typedef struct packed {
    logic load_in;
    logic exec;
    logic step;
    logic load_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_search;
    logic empty;
    logic hit;
    logic last;
  } sts_t;

endpackage

// ===== sv/deqs_if.sv =====
// ----------------------------------------------------------------------------
// deqs_in_if / deqs_out_if
// valid/ready channels for operation requests and their results
// ----------------------------------------------------------------------------
interface deqs_in_if;
  logic                 valid;
  logic                 ready;
  deqs_pkg::kind_t      kind;
  deqs_pkg::word_t      value;

  modport source (output valid, input ready, output kind, output value);
  modport sink   (input valid, output ready, input kind, input value);
endinterface

interface deqs_out_if;
  logic                               valid;
  logic                               ready;
  deqs_pkg::status_t                  status;
  logic                               found;
  logic [deqs_pkg::POS_W-1:0]         match_position;
  logic [deqs_pkg::OCC_W-1:0]         occupancy;

  modport source (output valid, input ready, output status, output found,
                  output match_position, output occupancy);
  modport sink   (input valid, output ready, input status, input found,
                  input match_position, input occupancy);
endinterface

// ===== sv/double_ended_queue_with_search.sv =====
// push, drop and unused kinds: transfer in, execute, then the result is loaded once the slot is free
// search: execute, then n entries compared (0 on an empty store, else 1 to DEPTH), then the result is loaded
// one item at a time, a new one taken only once the last result is loaded; a search compares one entry per cycle
// a new item is taken while an earlier result waits; a result waits for a free slot
// reset clears front pointer, count and handshake state; the word store is not cleared
// ----------------------------------------------------------------------------
// double_ended_queue_with_search
// bounded ring-store deque of 32-bit words with front-to-back key search
// ----------------------------------------------------------------------------
module double_ended_queue_with_search #(
  parameter int DEPTH = deqs_pkg::DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  deqs_in_if.sink     in_if,
  deqs_out_if.source  out_if
);

  deqs_pkg::cmd_t cmd;
  deqs_pkg::sts_t sts;

  deqs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  deqs_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_kind            (in_if.kind),
    .in_value           (in_if.value),
    .out_status         (out_if.status),
    .out_found          (out_if.found),
    .out_match_position (out_if.match_position),
    .out_occupancy      (out_if.occupancy)
  );

endmodule

// ===== sv/deqs_ram.sv =====
// ----------------------------------------------------------------------------
// deqs_ram
// generic single-write single-read ram with registered read data
// ----------------------------------------------------------------------------
module deqs_ram #(
  parameter int WIDTH = deqs_pkg::WORD_W,
  parameter int DEPTH = deqs_pkg::DEPTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/deqs_dp.sv =====
// ----------------------------------------------------------------------------
// deqs_dp
// ring pointers, word store, key compare and result registers
// ----------------------------------------------------------------------------
module deqs_dp #(
  parameter int DEPTH = deqs_pkg::DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  deqs_pkg::cmd_t                 cmd,
  output deqs_pkg::sts_t                 sts,
  input  deqs_pkg::kind_t                in_kind,
  input  deqs_pkg::word_t                in_value,
  output deqs_pkg::status_t              out_status,
  output logic                           out_found,
  output logic [deqs_pkg::POS_W-1:0]     out_match_position,
  output logic [deqs_pkg::OCC_W-1:0]     out_occupancy
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  deqs_pkg::kind_t   kind_r;
  deqs_pkg::word_t   key_r;
  logic [AW-1:0]     front_r;
  logic [CW-1:0]     count_r;
  logic [CW-1:0]     cmp_idx_r;
  deqs_pkg::status_t res_status_r;
  logic              res_found_r;
  logic [CW-1:0]     res_pos_r;
  deqs_pkg::status_t out_status_r;
  logic              out_found_r;
  logic [deqs_pkg::POS_W-1:0] out_pos_r;
  logic [deqs_pkg::OCC_W-1:0] out_occ_r;

  logic              full;
  logic              empty;
  logic [AW-1:0]     front_dec;
  logic [AW-1:0]     front_inc;
  logic [CW-1:0]     idx_inc;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [AW-1:0]     ram_raddr;
  deqs_pkg::word_t   ram_rdata;
  logic              hit;
  logic              last;

  // front plus offset, modulo depth; offset never exceeds depth
  function automatic logic [AW-1:0] ring(input logic [AW-1:0] base,
                                         input logic [CW-1:0] off);
    logic [CW:0] sum;
    sum = (CW+1)'(base) + (CW+1)'(off);
    if (sum >= (CW+1)'(DEPTH)) begin
      sum = sum - (CW+1)'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  assign full      = (count_r == CW'(DEPTH));
  assign empty     = (count_r == '0);
  assign front_dec = (front_r == '0) ? AW'(DEPTH - 1) : front_r - AW'(1);
  assign front_inc = (front_r == AW'(DEPTH - 1)) ? '0 : front_r + AW'(1);
  assign idx_inc   = cmp_idx_r + CW'(1);

  assign ram_we    = cmd.exec && !full &&
                     (kind_r inside {deqs_pkg::KIND_PUSH_FRONT, deqs_pkg::KIND_PUSH_BACK});
  assign ram_waddr = (kind_r == deqs_pkg::KIND_PUSH_FRONT) ? front_dec
                                                           : ring(front_r, count_r);
  assign ram_raddr = cmd.exec ? ring(front_r, '0) : ring(front_r, idx_inc);

  deqs_ram #(
    .WIDTH (deqs_pkg::WORD_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (key_r),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign hit  = (ram_rdata == key_r);
  assign last = (idx_inc == count_r);

  assign sts.is_search = (kind_r == deqs_pkg::KIND_SEARCH);
  assign sts.empty     = empty;
  assign sts.hit       = hit;
  assign sts.last      = last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      count_r <= '0;
    end else if (cmd.exec) begin
      case (kind_r)
        deqs_pkg::KIND_PUSH_FRONT: begin
          if (!full) begin
            front_r <= front_dec;
            count_r <= count_r + CW'(1);
          end
        end
        deqs_pkg::KIND_PUSH_BACK: begin
          if (!full) begin
            count_r <= count_r + CW'(1);
          end
        end
        deqs_pkg::KIND_DROP_FRONT: begin
          if (!empty) begin
            front_r <= front_inc;
            count_r <= count_r - CW'(1);
          end
        end
        deqs_pkg::KIND_DROP_BACK: begin
          if (!empty) begin
            count_r <= count_r - CW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      kind_r <= in_kind;
      key_r  <= in_value;
    end
    if (cmd.exec) begin
      res_found_r <= 1'b0;
      res_pos_r   <= '0;
      cmp_idx_r   <= '0;
      case (kind_r)
        deqs_pkg::KIND_PUSH_FRONT,
        deqs_pkg::KIND_PUSH_BACK: begin
          res_status_r <= full ? deqs_pkg::ST_FULL : deqs_pkg::ST_OK;
        end
        deqs_pkg::KIND_DROP_FRONT,
        deqs_pkg::KIND_DROP_BACK,
        deqs_pkg::KIND_SEARCH: begin
          res_status_r <= empty ? deqs_pkg::ST_EMPTY : deqs_pkg::ST_OK;
        end
        default: begin
          res_status_r <= deqs_pkg::ST_OK;
        end
      endcase
    end
    if (cmd.step) begin
      if (hit) begin
        res_found_r <= 1'b1;
        res_pos_r   <= cmp_idx_r;
      end else if (!last) begin
        cmp_idx_r <= idx_inc;
      end
    end
    if (cmd.load_out) begin
      out_status_r <= res_status_r;
      out_found_r  <= res_found_r;
      out_pos_r    <= deqs_pkg::POS_W'(res_pos_r);
      out_occ_r    <= deqs_pkg::OCC_W'(count_r);
    end
  end

  assign out_status         = out_status_r;
  assign out_found          = out_found_r;
  assign out_match_position = out_pos_r;
  assign out_occupancy      = out_occ_r;

endmodule

// ===== sv/deqs_ctrl.sv =====
// ----------------------------------------------------------------------------
// deqs_ctrl
// sequencer for one operation at a time and the result slot handshake
// ----------------------------------------------------------------------------
module deqs_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output deqs_pkg::cmd_t cmd,
  input  deqs_pkg::sts_t sts
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_SRCH = 2'd2;
  localparam logic [1:0] S_POST = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;
  logic       slot_free;

  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = (sts.is_search && !sts.empty) ? S_SRCH : S_POST;
      end
      S_SRCH: begin
        cmd.step = 1'b1;
        if (sts.hit || sts.last) begin
          state_nxt = S_POST;
        end
      end
      S_POST: begin
        if (slot_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd))
    else $error("more than one datapath command at once");

  a_load_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_ready))
    else $error("result loaded over an untaken result");

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_EXEC))
    else $error("accepted item not executed next cycle");

  a_search_end: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.step && (sts.hit || sts.last)) |=> (state_r == S_POST))
    else $error("search did not stop on hit or last entry");

  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_valid_r)
    else $error("loaded result not presented");
`endif

endmodule
